@@ src/ftm_pkg.sv @@
// Package for the FSK tone modulator: field widths, register indexes, reset values,
// sine polynomial coefficients and the command and status types between controller
// and datapath. Depends on nothing.
package ftm_pkg;

    // Default values for the top-level parameters.
    localparam int PHASE_BITS_DEF = 32;
    localparam int TABLE_BITS_DEF = 8;
    localparam int MAX_RUN_DEF    = 64;

    // Field and register widths.
    localparam int SAMPLE_W   = 8;
    localparam int RATE_W     = 16;
    localparam int STEP_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP  = 2'd3;

    // Register values after reset.
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 16'd22100;
    localparam logic [RATE_W-1:0] BIT_RATE_RST    = 16'd1200;
    localparam logic [STEP_W-1:0] MARK_STEP_RST   = 32'd233210893;
    localparam logic [STEP_W-1:0] SPACE_STEP_RST  = 32'd427553305;

    // Quarter-wave sine polynomial in Q15, and the output scaling.
    localparam logic [11:0] SIN_K3     = 12'd2611;
    localparam logic [14:0] SIN_K2     = 15'd21167;
    localparam logic [15:0] SIN_K1     = 16'd51472;
    localparam logic [15:0] SIN_FULL   = 16'd32768;
    localparam logic [6:0]  MAG_SCALE  = 7'd127;
    localparam logic [22:0] MAG_ROUND  = 23'd16384;
    localparam logic [7:0]  MAG_MAX    = 8'd127;
    localparam logic [7:0]  SAMPLE_MID = 8'd127;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // latch the tone step for a newly accepted bit
        logic issue;  // produce one sample and advance phase and timing
        logic last;   // the issued sample closes the run
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic adv;      // sample pipeline moves this cycle
        logic bit_end;  // timing sum has reached the sample rate
    } t_ctrl_stat;

endpackage

@@ src/fsk_tone_modulator.sv @@
// Top level of the continuous-phase FSK tone modulator: configuration registers,
// controller and datapath. Depends on ftm_pkg, ftm_ctrl and ftm_datapath.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_data_bit
//  output    out        o_out_valid / i_out_stall o_sample, o_bit_done
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Each accepted bit produces a run of N samples, where N is the number of sample periods
// until the timing accumulator reaches sample_rate, capped at MAX_RUN. A transaction on the
// input is accepted first; then, while the pipeline is not frozen, one sample is issued per
// cycle into the six-stage sine pipeline; with the reset rates a run has 18 or 19 samples.
// Reset is synchronous and active low; it clears the phase and timing accumulators and
// restores the register reset values. No clearing pass is needed.
// A stall on a valid output freezes the whole sine pipeline and the issue of samples; the
// input stays stalled until the last sample of the current run has been issued.
module fsk_tone_modulator #(
    parameter int PHASE_BITS = ftm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = ftm_pkg::TABLE_BITS_DEF,
    parameter int MAX_RUN    = ftm_pkg::MAX_RUN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_data_bit,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ftm_pkg::SAMPLE_W-1:0]     o_sample,
    output logic                             o_bit_done,
    input  logic                             i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ftm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [ftm_pkg::RATE_W-1:0] r_sample_rate;
    logic [ftm_pkg::RATE_W-1:0] r_bit_rate;
    logic [ftm_pkg::STEP_W-1:0] r_mark_step;
    logic [ftm_pkg::STEP_W-1:0] r_space_step;

    ftm_pkg::t_ctrl_cmd  w_cmd;
    ftm_pkg::t_ctrl_stat w_stat;

    // Tone step writes take effect from the next accepted bit, rate writes from the next issued
    // sample; the register index space is fully decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= ftm_pkg::SAMPLE_RATE_RST;
            r_bit_rate    <= ftm_pkg::BIT_RATE_RST;
            r_mark_step   <= ftm_pkg::MARK_STEP_RST;
            r_space_step  <= ftm_pkg::SPACE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ftm_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[ftm_pkg::RATE_W-1:0];
                ftm_pkg::CFG_BIT_RATE:    r_bit_rate    <= i_cfg_data[ftm_pkg::RATE_W-1:0];
                ftm_pkg::CFG_MARK_STEP:   r_mark_step   <= i_cfg_data[ftm_pkg::STEP_W-1:0];
                ftm_pkg::CFG_SPACE_STEP:  r_space_step  <= i_cfg_data[ftm_pkg::STEP_W-1:0];
            endcase
        end
    end

    // The controller sequences one run per accepted bit.
    ftm_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the persistent phase and timing state and the sine pipeline.
    ftm_datapath #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_data_bit    (i_data_bit),
        .i_sample_rate (r_sample_rate),
        .i_bit_rate    (r_bit_rate),
        .i_mark_step   (r_mark_step),
        .i_space_step  (r_space_step),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_sample      (o_sample),
        .o_bit_done    (o_bit_done)
    );

    // An accepted bit always starts a run, which blocks the next transaction.
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted bit");

    // Samples are only issued while a run is in progress.
    a_no_issue_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_cmd.issue)
        else $error("sample issued with no bit in progress");

    // A sample is never issued while the pipeline is frozen by the output stall.
    a_issue_follows_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_cmd.issue)
        else $error("sample issued into a stalled pipeline");

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

@@ src/ftm_sine.sv @@
// Six-stage sine sample pipeline of the FSK tone modulator, ending in the output register.
// Depends on ftm_pkg.
module ftm_sine #(
    parameter int PHASE_BITS = ftm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = ftm_pkg::TABLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_last,
    input  logic [PHASE_BITS-1:0]         i_phase,
    output logic                          o_valid,
    output logic [ftm_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                          o_bit_done
);

    logic [TABLE_BITS-1:0] w_idx;
    logic [1:0]            w_quad;
    logic [15:0]           w_z0;
    logic [15:0]           w_z;
    logic [31:0]           w_p2;
    logic [27:0]           w_p3;
    logic [30:0]           w_p4;
    logic [31:0]           w_p5;
    logic [16:0]           w_s17;
    logic [22:0]           w_p6;
    logic [6:0]            w_mag;

    // Pipeline control, reset.
    logic [5:1] r_vld;
    // Payload, no reset; r_out_vld below is pipeline control and is reset.
    logic [4:0] r_last;
    logic [1:0] r_quad [1:5];
    logic [15:0] r_s1_z, r_s2_z, r_s3_z, r_s4_z;
    logic [15:0] r_s2_z2, r_s3_z2;
    logic [14:0] r_s3_t1;
    logic [15:0] r_s4_t2;
    logic [15:0] r_s5_s;
    logic [ftm_pkg::SAMPLE_W-1:0] r_sample;
    logic r_done;
    logic r_out_vld;

    assign w_idx  = i_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign w_quad = w_idx[TABLE_BITS-1 -: 2];
    assign w_z0   = 16'({w_idx[TABLE_BITS-3:0], {(17-TABLE_BITS){1'b0}}});
    assign w_z    = w_quad[0] ? (ftm_pkg::SIN_FULL - w_z0) : w_z0;

    assign w_p2 = r_s1_z * r_s1_z;
    assign w_p3 = ftm_pkg::SIN_K3 * r_s2_z2;
    assign w_p4 = r_s3_t1 * r_s3_z2;
    assign w_p5 = r_s4_t2 * r_s4_z;
    assign w_s17 = w_p5[31:15];
    assign w_p6 = ftm_pkg::MAG_SCALE * r_s5_s + ftm_pkg::MAG_ROUND;
    assign w_mag = (w_p6[22:15] > ftm_pkg::MAG_MAX) ? ftm_pkg::MAG_MAX[6:0] : w_p6[21:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[4:1], i_valid};
            r_out_vld <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last  <= {r_last[3:0], i_last};
            r_quad[1] <= w_quad;
            r_quad[2] <= r_quad[1];
            r_quad[3] <= r_quad[2];
            r_quad[4] <= r_quad[3];
            r_quad[5] <= r_quad[4];
            r_s1_z  <= w_z;
            r_s2_z  <= r_s1_z;
            r_s2_z2 <= w_p2[30:15];
            r_s3_z  <= r_s2_z;
            r_s3_z2 <= r_s2_z2;
            r_s3_t1 <= ftm_pkg::SIN_K2 - {2'b00, w_p3[27:15]};
            r_s4_z  <= r_s3_z;
            r_s4_t2 <= ftm_pkg::SIN_K1 - w_p4[30:15];
            r_s5_s  <= (w_s17 > {1'b0, ftm_pkg::SIN_FULL}) ? ftm_pkg::SIN_FULL : w_s17[15:0];
            r_sample <= r_quad[5][1] ? (ftm_pkg::SAMPLE_MID - {1'b0, w_mag})
                                     : (ftm_pkg::SAMPLE_MID + {1'b0, w_mag});
            r_done  <= r_last[4];
        end
    end

    assign o_valid    = r_out_vld;
    assign o_sample   = r_sample;
    assign o_bit_done = r_done;

endmodule

@@ src/ftm_datapath.sv @@
// Datapath of the FSK tone modulator: phase and bit-timing accumulators and the sine
// pipeline fed by the phase. Depends on ftm_pkg and ftm_sine.
module ftm_datapath #(
    parameter int PHASE_BITS = ftm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = ftm_pkg::TABLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftm_pkg::t_ctrl_cmd            i_cmd,
    output ftm_pkg::t_ctrl_stat           o_stat,
    input  logic                          i_data_bit,
    input  logic [ftm_pkg::RATE_W-1:0]    i_sample_rate,
    input  logic [ftm_pkg::RATE_W-1:0]    i_bit_rate,
    input  logic [ftm_pkg::STEP_W-1:0]    i_mark_step,
    input  logic [ftm_pkg::STEP_W-1:0]    i_space_step,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [ftm_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                          o_bit_done
);

    logic [PHASE_BITS-1:0]       r_phase;
    logic [PHASE_BITS-1:0]       r_step;
    logic [ftm_pkg::RATE_W-1:0]  r_timing;
    logic [ftm_pkg::RATE_W-1:0]  n_timing;
    logic [ftm_pkg::RATE_W:0]    w_sum;
    logic [ftm_pkg::RATE_W:0]    w_rem;
    logic                        w_bit_end;
    logic                        w_adv;
    logic                        w_out_vld;

    assign w_sum     = {1'b0, r_timing} + {1'b0, i_bit_rate};
    assign w_rem     = w_sum - {1'b0, i_sample_rate};
    assign w_bit_end = (w_sum >= {1'b0, i_sample_rate});
    assign w_adv     = !w_out_vld || !i_out_stall;

    // Remainder after a bit end saturates below the sample rate.
    always_comb begin
        priority if (!w_bit_end) begin
            n_timing = w_sum[ftm_pkg::RATE_W-1:0];
        end else if (i_sample_rate == '0) begin
            n_timing = '0;
        end else if (w_rem >= {1'b0, i_sample_rate}) begin
            n_timing = i_sample_rate - 1'b1;
        end else begin
            n_timing = w_rem[ftm_pkg::RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_timing <= '0;
        end else if (i_cmd.issue) begin
            r_phase  <= r_phase + r_step;
            r_timing <= n_timing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step <= i_data_bit ? (PHASE_BITS)'(i_mark_step) : (PHASE_BITS)'(i_space_step);
        end
    end

    ftm_sine #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_sine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (i_cmd.issue),
        .i_last     (i_cmd.last),
        .i_phase    (r_phase),
        .o_valid    (w_out_vld),
        .o_sample   (o_sample),
        .o_bit_done (o_bit_done)
    );

    assign o_out_valid    = w_out_vld;
    assign o_stat.adv     = w_adv;
    assign o_stat.bit_end = w_bit_end;

endmodule

@@ src/ftm_ctrl.sv @@
// Controller of the FSK tone modulator: input handshake and per-bit run sequencing.
// Depends on ftm_pkg.
module ftm_ctrl #(
    parameter int MAX_RUN = ftm_pkg::MAX_RUN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ftm_pkg::t_ctrl_stat  i_stat,
    output ftm_pkg::t_ctrl_cmd   o_cmd
);

    localparam int CNT_W = $clog2(MAX_RUN);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_last;

    assign w_last = i_stat.bit_end || (r_cnt == CNT_W'(MAX_RUN - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                    n_cnt      = '0;
                end
            end
            ST_RUN: begin
                if (i_stat.adv) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.last  = w_last;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
